### src/bbs_pkg.sv
// Package of the blocked Bloom filter bit store: geometry constants and
// field widths. No dependencies; used by the interfaces and the top level.
package bbs_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned BLOCK_BYTES   = 64;
    localparam int unsigned NUM_BLOCKS    = 4096;
    localparam longint unsigned STORE_BYTES =
        longint'(NUM_BLOCKS) * longint'(BLOCK_BYTES);
    localparam int unsigned ADDR_W =
        (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    localparam int unsigned BLOCK_W = 12;
    localparam int unsigned BIT_W   = 9;
    localparam int unsigned SEL_W   = $clog2(BITS_PER_BYTE);
    localparam int unsigned BYTE_W  = BIT_W - SEL_W;

    typedef logic [BITS_PER_BYTE-1:0] t_byte;
    typedef logic [ADDR_W-1:0]        t_addr;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_QUERY  = 1'b1
    } t_kind;

endpackage

### src/bbs_if.sv
// Valid/ready channel interfaces of the bit store: one for input words and
// one for result words. Depends on bbs_pkg for the field widths.
interface bbs_in_if import bbs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [BLOCK_W-1:0] block_number;
    logic [BIT_W-1:0]   bit_pos;
    logic               last;

    modport source (output valid, kind, block_number, bit_pos, last, input ready);
    modport sink   (input valid, kind, block_number, bit_pos, last, output ready);
endinterface

interface bbs_out_if ();
    logic valid;
    logic ready;
    logic present;

    modport source (output valid, present, input ready);
    modport sink   (input valid, present, output ready);
endinterface

### src/blocked_bloom_bit_store.sv
// Top level of the blocked Bloom filter bit store: byte memory, two-stage
// read-modify-write pipeline and result register. Depends on bbs_pkg, bbs_if.

// The block holds NUM_BLOCKS blocks of BLOCK_BYTES bytes in one byte-wide
// synchronous memory. Each input word names a block and a bit inside it;
// an insert word sets that bit, a query word tests it and folds the result
// into a running flag, and the query word that carries last gives one
// result word telling whether every tested bit of the key was set. After
// reset the memory is cleared one byte per cycle; no input word is taken
// during that pass. After it, one word is accepted every cycle while the
// pipeline is not held: the memory read of a word and the write-back of
// the word before it overlap, and a byte written by the previous word is
// forwarded around the registered read of the memory, so back-to-back hits
// on the same byte are exact. A result word passes from the second stage
// into the output register once its last word has been accepted. While
// a result waits in the output register and the next result would need that
// register, the pipeline holds and input ready drops.
module blocked_bloom_bit_store
    import bbs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbs_in_if.sink    i_in,
    bbs_out_if.source o_out
);

    // Byte memory and its registered read port.
    t_byte r_mem [STORE_BYTES];
    t_byte r_rd_data;

    // Clearing pass after reset.
    logic  r_clearing;
    t_addr r_clr_addr;

    // Second stage: the word whose byte is being read back.
    logic  r_s1_valid;
    logic  r_s1_kind;
    logic  r_s1_last;
    logic  r_s1_ok;
    t_addr r_s1_addr;
    t_byte r_s1_mask;

    // Forwarded byte for a read that raced the previous word's write.
    logic  r_fwd_hit;
    t_byte r_fwd_data;

    logic  r_all_set;
    logic  r_out_valid;
    logic  r_out_present;

    // First stage: decode the incoming word.
    logic [BYTE_W-1:0] in_byte;
    logic [SEL_W-1:0]  in_sel;
    logic              in_ok;
    t_addr             in_addr;
    t_byte             in_mask;
    logic              accept;

    // Second stage: merge and decide.
    t_byte s1_cur;
    t_byte s1_wdata;
    logic  s1_wr_en;
    logic  s1_hit;
    logic  s1_flag;
    logic  s1_result;
    logic  s1_adv;

    // Memory write port, shared by the clearing pass and inserts.
    logic  mem_we;
    t_addr mem_waddr;
    t_byte mem_wdata;

    always_comb begin
        in_byte = i_in.bit_pos[BIT_W-1:SEL_W];
        in_sel  = i_in.bit_pos[SEL_W-1:0];
        in_ok   = (32'(i_in.block_number) < NUM_BLOCKS) && (32'(in_byte) < BLOCK_BYTES);
        in_addr = t_addr'(t_addr'(i_in.block_number) * t_addr'(BLOCK_BYTES))
                + t_addr'(in_byte);
        in_mask = t_byte'(1) << in_sel;
    end

    always_comb begin
        s1_cur    = r_fwd_hit ? r_fwd_data : r_rd_data;
        s1_wdata  = s1_cur | r_s1_mask;
        s1_hit    = r_s1_ok && ((s1_cur & r_s1_mask) != '0);
        s1_flag   = r_all_set && s1_hit;
        s1_result = r_s1_valid && (r_s1_kind == KIND_QUERY) && r_s1_last;
        // The second stage moves on unless its result has nowhere to go.
        s1_adv    = !s1_result || !r_out_valid || o_out.ready;
        s1_wr_en  = r_s1_valid && s1_adv && (r_s1_kind == KIND_INSERT) && r_s1_ok;
    end

    assign i_in.ready    = !r_clearing && (!r_s1_valid || s1_adv);
    assign accept        = i_in.valid && i_in.ready;
    assign o_out.valid   = r_out_valid;
    assign o_out.present = r_out_present;

    always_comb begin
        if (r_clearing) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else begin
            mem_we    = s1_wr_en;
            mem_waddr = r_s1_addr;
            mem_wdata = s1_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (accept) begin
            r_rd_data <= r_mem[in_addr];
        end
    end

    // Payload of the second stage and the forwarding register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_kind  <= i_in.kind;
            r_s1_last  <= i_in.last;
            r_s1_ok    <= in_ok;
            r_s1_addr  <= in_addr;
            r_s1_mask  <= in_mask;
            r_fwd_data <= s1_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing    <= 1'b1;
            r_clr_addr    <= '0;
            r_s1_valid    <= 1'b0;
            r_fwd_hit     <= 1'b0;
            r_all_set     <= 1'b1;
            r_out_valid   <= 1'b0;
            r_out_present <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + t_addr'(1);
                if (r_clr_addr == t_addr'(STORE_BYTES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end

            if (accept) begin
                r_s1_valid <= 1'b1;
                // The memory returns the old byte when the word ahead writes
                // the same address at this very edge.
                r_fwd_hit  <= s1_wr_en && (r_s1_addr == in_addr);
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
                r_fwd_hit  <= 1'b0;
            end

            if (r_s1_valid && s1_adv) begin
                if (r_s1_last) begin
                    r_all_set <= 1'b1;
                end else if (r_s1_kind == KIND_QUERY) begin
                    r_all_set <= s1_flag;
                end
            end

            if (s1_result && s1_adv) begin
                r_out_valid   <= 1'b1;
                r_out_present <= s1_flag;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // No input word may enter while the memory is still being cleared.
    a_no_accept_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !accept)
        else $error("input accepted during clearing pass");

    // Forwarding only ever applies to a word that sits in the second stage.
    a_fwd_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_s1_valid)
        else $error("forwarded byte without a second-stage word");

    // The end of a key always restores the running flag.
    a_flag_restored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s1_adv && r_s1_last) |=> r_all_set)
        else $error("running flag not restored after end of key");

    // A held result is never overwritten before it is taken.
    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> (r_out_valid && $stable(r_out_present)))
        else $error("pending result lost");

endmodule

### verif/bbs_membership_checker.sv
// Result checker of the blocked Bloom filter bit store: keeps its own copy of the
// filter bytes and flags every result word that disagrees with it.
// Depends on bbs_pkg and on the channel interfaces in bbs_if.
module bbs_membership_checker
    import bbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    bbs_in_if    i_in_mon,
    bbs_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STORE_DEPTH = int'(STORE_BYTES);

    bit [BITS_PER_BYTE-1:0] filter_bytes [0:STORE_DEPTH-1];
    bit                     key_all_set = 1'b1;
    bit                     expected_present [$];
    int                     mismatches = 0;

    // Applies one accepted word to the filter copy; a query word that closes a
    // key queues the answer the block owes for it.
    function automatic void apply_filter_word(t_kind kind, logic [BLOCK_W-1:0] blk,
                                              logic [BIT_W-1:0] bidx, logic last);
        int unsigned            byte_sel;
        int unsigned            addr;
        bit                     in_range;
        bit                     hit;
        bit [BITS_PER_BYTE-1:0] mask;
        byte_sel = int'(bidx) / BITS_PER_BYTE;
        in_range = (int'(blk) < NUM_BLOCKS) && (byte_sel < BLOCK_BYTES);
        addr     = int'(blk) * BLOCK_BYTES + byte_sel;
        mask     = BITS_PER_BYTE'(1) << (int'(bidx) % BITS_PER_BYTE);
        if (kind == KIND_INSERT) begin
            if (in_range)
                filter_bytes[addr] |= mask;
        end else begin
            hit = in_range && ((filter_bytes[addr] & mask) != '0);
            key_all_set = key_all_set && hit;
            if (last)
                expected_present.push_back(key_all_set);
        end
        // Any last word closes the key, insert or query.
        if (last)
            key_all_set = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        bit want;
        if (!i_rst_n) begin
            expected_present.delete();
            key_all_set = 1'b1;
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_present.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with nothing expected, present=%b",
                                 $time, i_out_mon.present);
                end else begin
                    want = expected_present.pop_front();
                    if (i_out_mon.present !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: present mismatch, expected %b got %b",
                                     $time, want, i_out_mon.present);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready)
                apply_filter_word(t_kind'(i_in_mon.kind), i_in_mon.block_number,
                                  i_in_mon.bit_pos, i_in_mon.last);
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_present.size();
    end

endmodule

### verif/tb_blocked_bloom_bit_store.sv
// Top of the bit store testbench: clock, reset, input words and result-side
// back-pressure, and the final verdict. Depends on bbs_pkg, bbs_if, the block
// itself and bbs_membership_checker, which does all the predicting.
module tb_blocked_bloom_bit_store;
    import bbs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // A key as the hashing front end would hand it over: one block and up to
    // eight bit positions inside it, sent as a run of words.
    typedef struct packed {
        logic [BLOCK_W-1:0]          blk;
        logic [3:0]                  n_bits;
        logic [7:0][BIT_W-1:0]       bits;
    } t_bloom_key;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bbs_in_if  in_ch ();
    bbs_out_if out_ch ();

    int fail_count;
    int pending_results;

    // When set, neither side idles any more; used for the tail of the run.
    bit quiet_tail = 1'b0;
    // Raised by the stimulus to ask the result side for one long hold-off.
    bit hold_results = 1'b0;
    int sent_words = 0;

    always #1 i_clk = ~i_clk;

    blocked_bloom_bit_store dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    bbs_membership_checker u_membership_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    // Offers one word and returns at the edge where it is taken. Valid is left
    // high, so a word that follows without a gap keeps it up with no glitch.
    // A random idle gap may come first; the fields carry noise during the gap
    // to catch a block that samples without valid.
    task automatic send_word(t_kind kind, logic [BLOCK_W-1:0] blk,
                             logic [BIT_W-1:0] bidx, logic last);
        int gap;
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            in_ch.valid        <= 1'b0;
            in_ch.kind         <= 1'($urandom);
            in_ch.block_number <= BLOCK_W'($urandom);
            in_ch.bit_pos      <= BIT_W'($urandom);
            in_ch.last         <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= kind;
        in_ch.block_number <= blk;
        in_ch.bit_pos      <= bidx;
        in_ch.last         <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        sent_words++;
    endtask

    task automatic send_key(t_kind kind, t_bloom_key key);
        for (int i = 0; i < int'(key.n_bits); i++)
            send_word(kind, key.blk, key.bits[i], (i == int'(key.n_bits) - 1));
    endtask

    // A hot key lands in blocks 0 to 3 and in the first four bytes, so that
    // queries of fresh hot keys hit set bits often and give both answers.
    function automatic t_bloom_key random_key(bit hot);
        t_bloom_key key;
        key.n_bits = 4'($urandom_range(1, 8));
        key.blk    = hot ? BLOCK_W'($urandom_range(0, 3)) : BLOCK_W'($urandom);
        for (int i = 0; i < 8; i++)
            key.bits[i] = hot ? BIT_W'($urandom_range(0, 31)) : BIT_W'($urandom);
        return key;
    endfunction

    // Result side: random stalls, and one long hold-off on request, counted
    // here, during which the block's output register fills and its input
    // ready has to drop.
    initial begin : result_receiver
        int stall_left = 0;
        int hold_left  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_results) begin
                hold_results = 1'b0;
                hold_left    = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 5);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Generous cap: it leaves room for the clearing pass after reset and for
    // the words themselves even with every gap and stall at its longest.
    initial begin : run_limit
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        t_bloom_key       key;
        t_bloom_key       stored_keys [$];
        int               choice;
        int               run_len;
        bit               hold_done  = 1'b0;
        bit               drain_done = 1'b0;

        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.kind         <= KIND_INSERT;
        in_ch.block_number <= '0;
        in_ch.bit_pos      <= '0;
        in_ch.last         <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The first word simply waits out the clearing pass.
        // Corners of the store: first and last block, first and last bit.
        send_word(KIND_INSERT, 12'd0,    9'd0,   1'b0);
        send_word(KIND_INSERT, 12'd0,    9'd511, 1'b1);
        send_word(KIND_INSERT, 12'd4095, 9'd0,   1'b0);
        send_word(KIND_INSERT, 12'd4095, 9'd511, 1'b1);
        send_word(KIND_QUERY,  12'd0,    9'd0,   1'b0);
        send_word(KIND_QUERY,  12'd0,    9'd511, 1'b1);
        send_word(KIND_QUERY,  12'd4095, 9'd511, 1'b1);
        // A plain miss in an otherwise populated block.
        send_word(KIND_QUERY,  12'd4095, 9'd1,   1'b1);
        // A miss early in the key keeps the answer at zero despite a later hit.
        send_word(KIND_QUERY,  12'd1,    9'd0,   1'b0);
        send_word(KIND_QUERY,  12'd0,    9'd0,   1'b1);
        // An insert carrying last ends a key after a miss and gives no result;
        // the next key starts clean and sees the bit that insert set.
        send_word(KIND_QUERY,  12'd2,    9'd5,   1'b0);
        send_word(KIND_INSERT, 12'd2,    9'd5,   1'b1);
        send_word(KIND_QUERY,  12'd2,    9'd5,   1'b1);
        // Mixed kinds in one key: the query sees the insert just before it.
        send_word(KIND_INSERT, 12'd7,    9'd100, 1'b0);
        send_word(KIND_QUERY,  12'd7,    9'd100, 1'b0);
        send_word(KIND_QUERY,  12'd7,    9'd101, 1'b1);
        // Back-to-back writes and reads of one byte exercise the forwarding.
        send_word(KIND_INSERT, 12'd9,    9'd8,   1'b0);
        send_word(KIND_INSERT, 12'd9,    9'd9,   1'b1);
        send_word(KIND_QUERY,  12'd9,    9'd8,   1'b0);
        send_word(KIND_QUERY,  12'd9,    9'd9,   1'b1);
        send_word(KIND_QUERY,  12'd9,    9'd10,  1'b1);
        // Blocks and bytes beyond the store cannot be named with these field
        // widths at the default geometry, so there is no out-of-range word.

        while (sent_words < 950) begin
            if (sent_words >= 850)
                quiet_tail = 1'b1;

            if (!hold_done && sent_words >= 300) begin
                // Long hold-off on results while single-word query keys keep
                // coming: the block has to fill up and push back.
                hold_done    = 1'b1;
                hold_results = 1'b1;
                repeat (40)
                    send_word(KIND_QUERY, BLOCK_W'($urandom_range(0, 3)),
                              BIT_W'($urandom_range(0, 31)), 1'b1);
            end else if (!drain_done && sent_words >= 600) begin
                // Sender pauses until every outstanding answer has come back.
                drain_done = 1'b1;
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
                wait (pending_results == 0);
                @(posedge i_clk);
            end

            choice = $urandom_range(0, 99);
            if (choice < 35) begin
                key = random_key($urandom_range(0, 1) == 0);
                send_key(KIND_INSERT, key);
                stored_keys.push_back(key);
                if (stored_keys.size() > 64)
                    void'(stored_keys.pop_front());
            end else if (choice < 65 && stored_keys.size() > 0) begin
                // A key inserted earlier: must come back present.
                send_key(KIND_QUERY, stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
            end else if (choice < 80 && stored_keys.size() > 0) begin
                // Earlier key with one bit moved: usually, not always, absent.
                key = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                key.bits[$urandom_range(0, int'(key.n_bits) - 1)] = BIT_W'($urandom);
                send_key(KIND_QUERY, key);
            end else if (choice < 90) begin
                send_key(KIND_QUERY, random_key($urandom_range(0, 1) == 0));
            end else begin
                // Broken key: inserts and queries interleaved in one run.
                key     = random_key(1'b1);
                run_len = $urandom_range(2, 6);
                for (int i = 0; i < run_len; i++)
                    send_word(t_kind'($urandom_range(0, 1)), key.blk,
                              key.bits[i], (i == run_len - 1));
            end
        end

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_results == 0);
        // Wait on so that a spurious late result word is still seen.
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
